>>> rtl/b64e_pkg.sv
package b64e_pkg;

  localparam int unsigned MAX_CHARS   = 5;
  localparam int unsigned CHAR_IDX_W  = $clog2(MAX_CHARS);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [7:0] NL_CHAR        = 8'h0A;
  localparam logic [7:0] PAD_CHAR       = 8'h3D;
  localparam logic [7:0] LIMIT_RESET    = 8'd72;
  localparam logic [8:0] GROUP_CHARS    = 9'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WRAP_ENABLE = 1'b0,
    REG_LINE_LIMIT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_ONE  = 2'd1,
    PHASE_TWO  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    logic       wrap_enable;
    logic [7:0] line_limit;
  } cfg_t;

  // Characters produced by one byte, in emit order.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CHAR_IDX_W-1:0]     count;
    logic                      last;
  } job_t;

  // Map a 6-bit value onto the standard alphabet.
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      sym = 8'h41 + w;
    end else if (v < 6'd52) begin
      sym = 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      sym = 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      sym = 8'h2B;
    end else begin
      sym = 8'h2F;
    end
  endfunction

endpackage

>>> rtl/b64e_front.sv
module b64e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  b64e_pkg::byte_item_t item,
  input  b64e_pkg::cfg_t      cfg,
  output b64e_pkg::job_t      job
);

  b64e_pkg::phase_t                group_phase, group_phase_next;
  logic [3:0]                      carry_bits, carry_bits_next;
  logic [7:0]                      line_count, line_count_next;
  logic [8:0]                      cnt, sum;
  logic [b64e_pkg::CHAR_IDX_W-1:0] n;

  always_comb begin
    cnt              = {1'b0, line_count};
    sum              = cnt + b64e_pkg::GROUP_CHARS;
    group_phase_next = group_phase;
    carry_bits_next  = carry_bits;
    n                = '0;
    job              = '0;
    job.last         = item.last_byte;

    unique case (group_phase)
      b64e_pkg::PHASE_ONE: begin
        job.chars[n]     = b64e_pkg::sym({carry_bits[1:0], item.data_byte[7:4]});
        n                = n + 1'b1;
        carry_bits_next  = item.data_byte[3:0];
        group_phase_next = b64e_pkg::PHASE_TWO;
      end
      b64e_pkg::PHASE_TWO: begin
        job.chars[n]     = b64e_pkg::sym({carry_bits, item.data_byte[7:6]});
        n                = n + 1'b1;
        job.chars[n]     = b64e_pkg::sym(item.data_byte[5:0]);
        n                = n + 1'b1;
        carry_bits_next  = '0;
        group_phase_next = b64e_pkg::PHASE_IDLE;
        cnt              = sum;
        if (sum >= {1'b0, cfg.line_limit}) begin
          if (cfg.wrap_enable) begin
            job.chars[n] = b64e_pkg::NL_CHAR;
            n            = n + 1'b1;
          end
          cnt = '0;
        end
      end
      default: begin
        job.chars[n]     = b64e_pkg::sym(item.data_byte[7:2]);
        n                = n + 1'b1;
        carry_bits_next  = {2'b00, item.data_byte[1:0]};
        group_phase_next = b64e_pkg::PHASE_ONE;
      end
    endcase

    line_count_next = cnt[7:0];

    if (item.last_byte) begin
      if (group_phase_next == b64e_pkg::PHASE_ONE) begin
        job.chars[n] = b64e_pkg::sym({carry_bits_next[1:0], 4'b0000});
        n            = n + 1'b1;
        job.chars[n] = b64e_pkg::PAD_CHAR;
        n            = n + 1'b1;
        job.chars[n] = b64e_pkg::PAD_CHAR;
        n            = n + 1'b1;
        cnt          = cnt + b64e_pkg::GROUP_CHARS;
      end else if (group_phase_next == b64e_pkg::PHASE_TWO) begin
        job.chars[n] = b64e_pkg::sym({carry_bits_next, 2'b00});
        n            = n + 1'b1;
        job.chars[n] = b64e_pkg::PAD_CHAR;
        n            = n + 1'b1;
        cnt          = cnt + b64e_pkg::GROUP_CHARS;
      end
      if (cfg.wrap_enable && (cnt != 9'd0)) begin
        job.chars[n] = b64e_pkg::NL_CHAR;
        n            = n + 1'b1;
      end
      group_phase_next = b64e_pkg::PHASE_IDLE;
      carry_bits_next  = '0;
      line_count_next  = '0;
    end

    job.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= b64e_pkg::PHASE_IDLE;
      carry_bits  <= '0;
      line_count  <= '0;
    end else if (accept) begin
      group_phase <= group_phase_next;
      carry_bits  <= carry_bits_next;
      line_count  <= line_count_next;
    end
  end

endmodule

>>> rtl/b64e_queue.sv
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  input  logic           pop,
  output logic           head_valid,
  output b64e_pkg::job_t head_job,
  output logic           full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64e_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head_valid = (fill != '0);
  assign full       = (fill == FULL_CNT);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> rtl/b64e_back.sv
module b64e_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  b64e_pkg::job_t       head_job,
  output logic                 pop,
  output logic                 char_valid,
  input  logic                 char_stall,
  output b64e_pkg::char_item_t char_item
);

  logic [b64e_pkg::CHAR_IDX_W-1:0] idx;
  logic                            load, at_end;

  assign load   = head_valid && (!char_valid || !char_stall);
  assign at_end = (idx == head_job.count - 1'b1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      char_valid <= 1'b0;
    end else begin
      if (!char_valid || !char_stall) begin
        char_valid <= head_valid;
      end
      if (load) begin
        idx <= at_end ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_item.out_char  <= head_job.chars[idx];
      char_item.last_char <= head_job.last && at_end;
    end
  end

endmodule

>>> rtl/base64_encoder_line_wrap.sv
// Path: each taken byte is written into the job queue, and its first character is then
//   loaded from the queue head into the output register.
// Throughput: one character leaves per cycle from the single output register while char_stall
//   is low; a byte makes 1 to 5 characters, about 1.4 on average.
// Input bytes are taken back to back while the four-entry job queue has room.
// Reset (rst, synchronous, active high): wrap on, limit 72, group state and queue cleared.
module base64_encoder_line_wrap #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // raw bytes
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  b64e_pkg::byte_item_t               byte_item,
  // encoded characters
  output logic                               char_valid,
  input  logic                               char_stall,
  output b64e_pkg::char_item_t               char_item,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [b64e_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [b64e_pkg::CFG_DATA_W-1:0]    cfg_data
);

  b64e_pkg::cfg_t cfg;
  b64e_pkg::job_t new_job, head_job;
  logic           accept, q_full, head_valid, pop;

  // Register writes go straight into the config registers; the port never holds off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_enable <= 1'b1;
      cfg.line_limit  <= b64e_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (b64e_pkg::cfg_reg_t'(cfg_index))
        b64e_pkg::REG_WRAP_ENABLE: cfg.wrap_enable <= cfg_data[0];
        b64e_pkg::REG_LINE_LIMIT:  cfg.line_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Hold off the source only when the job queue is full.
  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;

  // Front: track group phase, leftover bits and line count; turn each byte
  // into the full list of characters it produces.
  b64e_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .cfg    (cfg),
    .job    (new_job)
  );

  // Queue: decouple byte intake from character output.
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_job   (new_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (q_full)
  );

  // Back: advance through the head job one character per cycle while the output is not
  // stalled; drop the job once its final character is loaded into the output register.
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

endmodule

>>> rtl/b64e_checker.sv
module b64e_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             byte_valid,
  input logic                             byte_stall,
  input b64e_pkg::byte_item_t             byte_item,
  input logic                             char_valid,
  input logic                             char_stall,
  input b64e_pkg::char_item_t             char_item,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);

  logic [7:0] c;
  assign c = char_item.out_char;

  a_reset_empty: assert property (@(posedge clk) rst |=> !char_valid && !byte_stall)
    else $error("output valid or input stalled right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_item))
    else $error("stalled character changed or dropped");

  a_charset: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (c == 8'h0A) || (c == 8'h2B) || (c == 8'h2F) || (c == 8'h3D) ||
                   (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A))
    else $error("character outside the base64 set");

  a_byte_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
    else $error("stalled input byte changed or dropped");

  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write held off");

endmodule

bind base64_encoder_line_wrap b64e_checker u_b64e_checker (.*);
